[sv/wfbc_pkg.sv]
// Shared types, constants and state codes for the windowed flow bin counter.
package wfbc_pkg;

    localparam int BIN_COUNT_DEF = 4096;
    localparam int BIN_SHIFT_DEF = 20;
    localparam int HIST_SIZE_DEF = 256;

    localparam int WINDOW_W = 20;
    localparam int TIME_W   = 40;
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int BIDX_W   = 8;
    localparam int DIST_W   = 13;
    localparam int BCNT_W   = 32;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(2000);
    localparam logic [DIST_W-1:0]   COUNT_MAX    = '1;

    localparam logic CMD_PACKET  = 1'b0;
    localparam logic CMD_READ    = 1'b1;
    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_BUCKET = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [TIME_W-1:0] time_us;
        logic [ADDR_W-1:0] dst_addr;
        logic [ADDR_W-1:0] src_addr;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
        logic [BIDX_W-1:0] bucket_index;
    } item_t;

    typedef struct packed {
        logic              kind;
        logic [DIST_W-1:0] distinct_bins;
        logic [BCNT_W-1:0] bucket_count;
    } result_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SWEEP
    } state_t;

endpackage

[sv/windowed_flow_bin_counter.sv]
// Top level of the windowed flow bin counter: control, bitmap and histogram memories.
//
// Counts distinct destination bins per time window and keeps a packet
// histogram by header hash. An item is taken when start is high and busy is
// low. Every result shows on result for exactly one cycle with done high and
// must be taken then, since there is no way to stall it. A packet or a bucket
// read holds busy high in its read state while the memory read data lands and,
// for a packet, the entry is written back. The next item can then be taken
// once busy is low. The result is formed in the read state and registered out
// with done. For a read, or for a packet that stays in its window, busy is
// already low in that cycle, so the next item may be taken there. A packet
// that closes a window also clears the bitmap, one row per cycle (32 bits
// wide when BIN_COUNT is at least 64). Its result shows during that sweep,
// and busy stays high through the read state and the whole sweep, so the next
// item waits until the sweep is over. After reset a clearing pass zeroes both
// memories with busy high. The window register can be written at any time
// (cfg_ready is always high) but should only change while the block is idle.
// BIN_COUNT and HIST_SIZE must be powers of two.
module windowed_flow_bin_counter
    import wfbc_pkg::*;
#(
    parameter int BIN_COUNT = BIN_COUNT_DEF,
    parameter int BIN_SHIFT = BIN_SHIFT_DEF,
    parameter int HIST_SIZE = HIST_SIZE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  item_t               item,
    output logic                done,
    output result_t             result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [WINDOW_W-1:0] cfg_data
);

    // Bitmap is packed into rows to keep the clearing sweep short.
    localparam int BIN_W     = $clog2(BIN_COUNT);
    localparam int ROW_W     = (BIN_COUNT >= 64) ? 32 : BIN_COUNT / 2;
    localparam int BIT_W     = $clog2(ROW_W);
    localparam int ROWS      = BIN_COUNT / ROW_W;
    localparam int ROW_AW    = $clog2(ROWS);
    localparam int HIST_W    = $clog2(HIST_SIZE);
    localparam int CLR_DEPTH = (ROWS > HIST_SIZE) ? ROWS : HIST_SIZE;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);
    localparam logic [CLR_W-1:0] ROW_LAST = CLR_W'(ROWS - 1);

    // Control state
    state_t              state_reg, state_next;
    logic [CLR_W-1:0]    sweep_reg, sweep_next;
    logic [WINDOW_W-1:0] window_reg, window_next;
    logic [TIME_W-1:0]   ws_reg, ws_next;
    logic                started_reg, started_next;
    logic [DIST_W-1:0]   distinct_reg, distinct_next;
    logic                done_reg, done_next;

    // Item held across the read-modify-write
    logic                cmd_reg, cmd_next;
    logic                in_window_reg, in_window_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [ROW_AW-1:0]   row_reg, row_next;
    logic [HIST_W-1:0]   hbkt_reg, hbkt_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    result_t             result_reg, result_next;

    // Accept-side datapath
    logic                accept;
    logic [TIME_W-1:0]   ws_eff;
    logic [TIME_W-1:0]   elapsed;
    logic                in_window;
    logic [ADDR_W-1:0]   dst_shifted;
    logic [BIN_W-1:0]    bin;
    logic [ADDR_W-1:0]   hash;
    logic [ADDR_W-1:0]   bidx_wide;

    // Memory ports
    logic                hist_we;
    logic [HIST_W-1:0]   hist_waddr, hist_raddr;
    logic [BCNT_W-1:0]   hist_wdata, hist_rdata;
    logic                bmp_we;
    logic [ROW_AW-1:0]   bmp_waddr, bmp_raddr;
    logic [ROW_W-1:0]    bmp_wdata, bmp_rdata;

    logic                bit_set;
    logic                mark;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    // First packet opens the window at its own time.
    assign ws_eff    = started_reg ? ws_reg : item.time_us;
    assign elapsed   = item.time_us - ws_eff;
    // Time going backwards counts as inside the window.
    assign in_window = (item.time_us < ws_eff) || (elapsed < TIME_W'(window_reg));

    assign dst_shifted = item.dst_addr >> BIN_SHIFT;
    assign bin         = dst_shifted[BIN_W-1:0];
    assign hash        = item.src_addr + item.dst_addr
                       + ADDR_W'(item.src_port) + ADDR_W'(item.dst_port);
    assign bidx_wide   = ADDR_W'(item.bucket_index);

    assign hist_raddr = (item.cmd == CMD_READ) ? bidx_wide[HIST_W-1:0] : hash[HIST_W-1:0];
    assign bmp_raddr  = bin[BIN_W-1:BIT_W];

    assign bit_set = bmp_rdata[bit_reg];
    assign mark    = (state_reg == S_READ) && (cmd_reg == CMD_PACKET) && in_window_reg;

    wfbc_ram #(
        .WIDTH (BCNT_W),
        .DEPTH (HIST_SIZE)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    wfbc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_bmp_ram (
        .clk   (clk),
        .we    (bmp_we),
        .waddr (bmp_waddr),
        .wdata (bmp_wdata),
        .raddr (bmp_raddr),
        .rdata (bmp_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sweep_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if ((cmd_reg == CMD_PACKET) && !in_window_reg)
                begin
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                if (sweep_reg == ROW_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory writes and result
    always_comb
    begin
        hist_we     = 1'b0;
        hist_waddr  = hbkt_reg;
        hist_wdata  = hist_rdata + BCNT_W'(1);
        bmp_we      = 1'b0;
        bmp_waddr   = sweep_reg[ROW_AW-1:0];
        bmp_wdata   = '0;
        sweep_next  = '0;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            S_CLEAR:
            begin
                hist_we    = 1'b1;
                hist_waddr = sweep_reg[HIST_W-1:0];
                hist_wdata = '0;
                bmp_we     = 1'b1;
                sweep_next = sweep_reg + CLR_W'(1);
            end
            S_IDLE:
            begin
            end
            S_READ:
            begin
                if (cmd_reg == CMD_READ)
                begin
                    done_next                 = 1'b1;
                    result_next.kind          = KIND_BUCKET;
                    result_next.distinct_bins = '0;
                    result_next.bucket_count  = hist_rdata;
                end
                else
                begin
                    hist_we = 1'b1;
                    if (in_window_reg)
                    begin
                        // Set the bin's bit in its row.
                        bmp_we    = !bit_set;
                        bmp_waddr = row_reg;
                        bmp_wdata = bmp_rdata | (ROW_W'(1) << bit_reg);
                    end
                    else
                    begin
                        done_next                 = 1'b1;
                        result_next.kind          = KIND_WINDOW;
                        result_next.distinct_bins = distinct_reg;
                        result_next.bucket_count  = '0;
                    end
                end
            end
            S_SWEEP:
            begin
                bmp_we     = 1'b1;
                sweep_next = sweep_reg + CLR_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Window and item bookkeeping
    always_comb
    begin
        window_next    = window_reg;
        ws_next        = ws_reg;
        started_next   = started_reg;
        distinct_next  = distinct_reg;
        cmd_next       = cmd_reg;
        in_window_next = in_window_reg;
        bit_next       = bit_reg;
        row_next       = row_reg;
        hbkt_next      = hbkt_reg;
        time_next      = time_reg;

        if (cfg_valid && cfg_ready)
        begin
            window_next = cfg_data;
        end

        if (accept)
        begin
            cmd_next       = item.cmd;
            in_window_next = in_window;
            bit_next       = bin[BIT_W-1:0];
            row_next       = bin[BIN_W-1:BIT_W];
            hbkt_next      = hash[HIST_W-1:0];
            time_next      = item.time_us;
            if ((item.cmd == CMD_PACKET) && !started_reg)
            begin
                ws_next      = item.time_us;
                started_next = 1'b1;
            end
        end

        if (mark && !bit_set && (distinct_reg != COUNT_MAX))
        begin
            distinct_next = distinct_reg + DIST_W'(1);
        end

        // Closing packet restarts the window at its own time.
        if ((state_reg == S_READ) && (cmd_reg == CMD_PACKET) && !in_window_reg)
        begin
            distinct_next = '0;
            ws_next       = time_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            sweep_reg    <= '0;
            window_reg   <= WINDOW_RESET;
            ws_reg       <= '0;
            started_reg  <= 1'b0;
            distinct_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            window_reg   <= window_next;
            ws_reg       <= ws_next;
            started_reg  <= started_next;
            distinct_reg <= distinct_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        in_window_reg <= in_window_next;
        bit_reg       <= bit_next;
        row_reg       <= row_next;
        hbkt_reg      <= hbkt_next;
        time_reg      <= time_next;
        result_reg    <= result_next;
    end

endmodule

[sv/wfbc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module wfbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/wfbc_checker.sv]
// Port-level checker for the windowed flow bin counter, bound to the top level.
module wfbc_checker
    import wfbc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // An accepted item keeps the block busy for its read-modify-write.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // A result always follows a busy cycle.
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without preceding work");

    // No result can appear on the cycle right after an accept.
    a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result too soon after accept");

    // Unused field of each result kind reads zero.
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (((result.kind == KIND_BUCKET) && (result.distinct_bins == '0))
               || ((result.kind == KIND_WINDOW) && (result.bucket_count == '0))))
        else $error("unused result field not zero");

endmodule

bind windowed_flow_bin_counter wfbc_checker u_wfbc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

[verif/tb_windowed_flow_bin_counter.sv]
// Self-checking bench for the windowed flow bin counter: directed and random traffic.
module tb_windowed_flow_bin_counter;
    timeunit 1ns;
    timeprecision 1ps;

    import wfbc_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int BIN_BITS      = $clog2(BIN_COUNT_DEF);
    // A closing packet sweeps the bitmap one 32-bit row per cycle after its beat.
    localparam int SETTLE_CYCLES = 2 + BIN_COUNT_DEF / 32 + 16;
    // Longest quiet stretch is the clearing pass after reset or a settle;
    // this is several times either.
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 160;
    localparam int MAX_PRINTED   = 100;

    localparam logic [WINDOW_W-1:0] WINDOW_MAX = '1;
    localparam logic [TIME_W-1:0]   TIME_MAX   = '1;

    // ------------------------------------------------------------------
    // Clock, reset and block ports. Every input has a known value at time 0.
    // ------------------------------------------------------------------
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    logic                busy;
    item_t               item      = '0;
    logic                done;
    result_t             result;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [WINDOW_W-1:0] cfg_data  = '0;

    always #HALF_PERIOD clk = ~clk;

    windowed_flow_bin_counter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow state of the block: window register, bitmap, window bookkeeping
    // and the hash histogram. Updated at the edge that accepts each beat.
    // ------------------------------------------------------------------
    logic [WINDOW_W-1:0]      window_len     = WINDOW_RESET;
    bit   [BIN_COUNT_DEF-1:0] bins_hit       = '0;
    logic [DIST_W-1:0]        bins_in_window = '0;
    logic [TIME_W-1:0]        window_open    = '0;
    bit                       window_live    = 1'b0;
    logic [BCNT_W-1:0]        bucket_hits [HIST_SIZE_DEF] = '{default: '0};

    // Results the block still owes, oldest first.
    result_t owed_reports [$];

    int mismatches   = 0;
    int quiet_cycles = 0;
    int n_packets    = 0;
    int n_reads      = 0;
    int n_windows    = 0;
    int n_buckets    = 0;
    int n_settings   = 0;

    // Stimulus clock in microseconds, and the bucket the latest packet landed in
    // (used to aim reads at buckets that are known to be nonzero).
    logic [TIME_W-1:0] now_us      = '0;
    logic [BIDX_W-1:0] last_bucket = '0;

    task automatic flag_mismatch(string msg);
        mismatches++;
        // keep the log bounded if the block is badly broken
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Work out what one accepted header does to the shadow state and queue
    // the result it causes, if any.
    task automatic tally_header(item_t hdr);
        result_t           rep;
        logic [ADDR_W-1:0] hash;
        int unsigned       slot;
        int unsigned       bucket;
        rep = '0;
        if (hdr.cmd == CMD_READ)
        begin
            // read only: no state changes, packet fields ignored
            rep.kind         = KIND_BUCKET;
            rep.bucket_count = bucket_hits[hdr.bucket_index % HIST_SIZE_DEF];
            owed_reports.push_back(rep);
            n_reads++;
        end
        else
        begin
            n_packets++;
            // first packet ever opens the window at its own time
            if (!window_live)
            begin
                window_open = hdr.time_us;
                window_live = 1'b1;
            end
            // a timestamp behind the window start still counts as inside
            if (hdr.time_us < window_open ||
                (hdr.time_us - window_open) < TIME_W'(window_len))
            begin
                slot = (hdr.dst_addr >> BIN_SHIFT_DEF) % BIN_COUNT_DEF;
                if (!bins_hit[slot])
                begin
                    bins_hit[slot] = 1'b1;
                    if (bins_in_window != COUNT_MAX)
                        bins_in_window++;
                end
            end
            else
            begin
                // closing packet reports, clears, reopens; it is not marked
                rep.kind          = KIND_WINDOW;
                rep.distinct_bins = bins_in_window;
                owed_reports.push_back(rep);
                bins_hit       = '0;
                bins_in_window = '0;
                window_open    = hdr.time_us;
            end
            // every packet lands in the histogram, closing or not
            hash   = hdr.src_addr + hdr.dst_addr + hdr.src_port + hdr.dst_port;
            bucket = hash % HIST_SIZE_DEF;
            bucket_hits[bucket] = bucket_hits[bucket] + 1'b1;
            last_bucket = BIDX_W'(bucket);
        end
    endtask

    // Compare one result beat, field by field, against the oldest owed one.
    task automatic match_report(result_t got);
        result_t want;
        if (owed_reports.size() == 0)
        begin
            flag_mismatch($sformatf("result with nothing owed: kind %0b bins %0d count %0d",
                                    got.kind, got.distinct_bins, got.bucket_count));
            return;
        end
        want = owed_reports.pop_front();
        if (got.kind !== want.kind)
            flag_mismatch($sformatf("kind %0b, want %0b", got.kind, want.kind));
        if (got.distinct_bins !== want.distinct_bins)
            flag_mismatch($sformatf("distinct_bins %0d, want %0d",
                                    got.distinct_bins, want.distinct_bins));
        if (got.bucket_count !== want.bucket_count)
            flag_mismatch($sformatf("bucket_count %0d, want %0d",
                                    got.bucket_count, want.bucket_count));
        if (want.kind == KIND_WINDOW)
            n_windows++;
        else
            n_buckets++;
    endtask

    // ------------------------------------------------------------------
    // Monitor and watchdog. All sampling is of pre-edge values, so the order
    // of processes inside a time step does not matter. A result shows only after
    // the read state that follows its accepting edge, so checks and predictions
    // on the same edge never refer to each other.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                match_report(result);
            if (start && !busy)
                tally_header(item);
            if (cfg_valid && cfg_ready)
            begin
                window_len = cfg_data;
                n_settings++;
            end
            if (done || (start && !busy) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: %0d cycles without a beat, %0d results owed",
                         QUIET_LIMIT, owed_reports.size());
                $display("FAIL windowed_flow_bin_counter");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver side. Tasks start and return on a rising edge. send_header leaves
    // start high so back-to-back beats need no extra assignment; hold_off and
    // drain_reports are the only places that lower it.
    // ------------------------------------------------------------------
    task automatic send_header(item_t hdr);
        item  <= hdr;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic hold_off(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Wait until every owed result is in, then let a full bitmap sweep pass so
    // the block is truly idle (a packet may cause no result yet still be busy).
    task automatic drain_reports();
        start <= 1'b0;
        @(posedge clk);
        while (owed_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(logic [WINDOW_W-1:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    // Packet header with random hash fields and junk in the read index.
    function automatic item_t packet_hdr(logic [TIME_W-1:0] t, logic [ADDR_W-1:0] dst);
        item_t hdr;
        hdr.cmd          = CMD_PACKET;
        hdr.time_us      = t;
        hdr.dst_addr     = dst;
        hdr.src_addr     = $urandom;
        hdr.src_port     = PORT_W'($urandom);
        hdr.dst_port     = PORT_W'($urandom);
        hdr.bucket_index = BIDX_W'($urandom);
        return hdr;
    endfunction

    // Bucket read; the packet fields carry random junk that must be ignored.
    function automatic item_t read_hdr(logic [BIDX_W-1:0] idx);
        item_t hdr;
        hdr              = packet_hdr(TIME_W'({$urandom, $urandom}), $urandom);
        hdr.cmd          = CMD_READ;
        hdr.bucket_index = idx;
        return hdr;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero-length window set before any packet: the first packet opens and
    // closes at once; later-than-start packets keep closing; packets behind
    // the window start are still marked.
    task automatic test_zero_window_open();
        write_window('0);
        send_header(packet_hdr(40'd100, 32'h0000_0000));  // opens and closes: 0
        send_header(packet_hdr(40'd100, 32'h0000_0000));  // elapsed 0 not below 0: closes
        send_header(packet_hdr(40'd50, 32'hFFFF_FFFF));   // behind start: top bin marked
        send_header(packet_hdr(40'd40, 32'h0010_0000));   // behind start: bin 1 marked
        send_header(packet_hdr(40'd100, 32'h0010_0000));  // closes with 2
        drain_reports();
    endtask

    // Default window: last microsecond inside, first microsecond outside,
    // duplicate bins, hash field extremes and reads at both index ends.
    task automatic test_window_bounds();
        item_t hdr;
        write_window(WINDOW_RESET);
        // window opened at 100, so 2099 is the last microsecond inside
        hdr          = packet_hdr(40'd2099, 32'hFFF0_0000);
        hdr.src_addr = '1;
        hdr.src_port = '1;
        hdr.dst_port = '1;
        send_header(hdr);
        send_header(packet_hdr(40'd2099, 32'hFFFF_FFFF));  // same bin, no new count
        hdr          = packet_hdr(40'd2099, 32'h0000_0000);
        hdr.src_addr = '0;
        hdr.src_port = '0;
        hdr.dst_port = '0;
        send_header(hdr);                                  // hash 0
        send_header(packet_hdr(40'd2100, $urandom));       // at window length: closes with 2
        send_header(read_hdr('0));
        send_header(read_hdr('1));
        send_header(read_hdr(8'hFD));                      // bucket of the all-ones header
        drain_reports();
    endtask

    // Random traffic in phases, one window setting per phase. Mostly forward
    // time with steps sized to the window, plus jumps, backward stamps and
    // reads. One phase in six runs with no sender gaps.
    task automatic test_random_traffic();
        item_t               hdr;
        logic [WINDOW_W-1:0] len;
        logic [TIME_W-1:0]   back;
        logic [BIN_BITS-1:0] bin_pool [8];
        int unsigned         span;
        int unsigned         roll;
        int unsigned         pause_at;
        bit                  steady;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            steady = (phase % 6 == 2);
            case (phase % 6)
                0:
                begin
                    len  = WINDOW_W'(1);
                    span = 1;
                end
                1:
                begin
                    len  = WINDOW_W'($urandom_range(2, 64));
                    span = len / 6 + 1;
                end
                2:
                begin
                    len  = WINDOW_RESET;
                    span = len / 6 + 1;
                end
                3:
                begin
                    len  = '0;
                    span = 1;
                end
                4:
                begin
                    len  = WINDOW_W'($urandom_range(65, WINDOW_MAX - 1));
                    span = len / 6 + 1;
                end
                // long window, tight steps: many distinct bins per window
                default:
                begin
                    len  = WINDOW_MAX;
                    span = 16;
                end
            endcase
            write_window(len);
            // a few hot bins per phase so windows see repeats
            foreach (bin_pool[i])
                bin_pool[i] = BIN_BITS'($urandom);
            pause_at = $urandom_range(20, PHASE_ITEMS - 20);

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 15)
                begin
                    hdr = read_hdr(($urandom_range(0, 1) == 0) ? last_bucket
                                                               : BIDX_W'($urandom));
                end
                else
                begin
                    hdr = packet_hdr(now_us,
                                     ($urandom_range(0, 1) == 0)
                                         ? {bin_pool[$urandom_range(0, 7)],
                                            BIN_SHIFT_DEF'($urandom)}
                                         : $urandom);
                    if (roll < 18)
                    begin
                        // stamp behind the stimulus clock
                        back = TIME_W'($urandom_range(0, span * 8));
                        hdr.time_us = (back > now_us) ? '0 : now_us - back;
                    end
                    else if (roll < 21)
                    begin
                        // idle link: big jump forward
                        now_us      = now_us + $urandom_range(0, 32'h0FFF_FFFF);
                        hdr.time_us = now_us;
                    end
                    else
                    begin
                        now_us      = now_us + $urandom_range(0, span);
                        hdr.time_us = now_us;
                    end
                end
                send_header(hdr);

                if (k == pause_at)
                    drain_reports();
                else if (!steady)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll >= 90)
                        hold_off($urandom_range(8, 40));
                    else if (roll >= 50)
                        hold_off($urandom_range(1, 3));
                end
            end
            drain_reports();
        end
    endtask

    // Top of the 40-bit time range with the widest window. Runs last since it
    // leaves the window start at the end of time.
    task automatic test_time_extremes();
        write_window(WINDOW_MAX);
        send_header(packet_hdr(40'hFF_FFF0_0000, $urandom));  // far past: closes
        send_header(packet_hdr(TIME_MAX - 1, $urandom));      // one short of window: marked
        send_header(packet_hdr(TIME_MAX, $urandom));          // exactly window: closes with 1
        send_header(packet_hdr('0, $urandom));                // far behind start: marked
        send_header(read_hdr(8'hA5));
        drain_reports();
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset once, then the tests in turn, then the verdict.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_zero_window_open();
        test_window_bounds();
        test_random_traffic();
        test_time_extremes();

        if (owed_reports.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", owed_reports.size()));

        $display("covered %0d packets and %0d bucket reads over %0d window settings",
                 n_packets, n_reads, n_settings);
        $display("checked %0d closed windows and %0d bucket results, %0d mismatches",
                 n_windows, n_buckets, mismatches);
        if (mismatches == 0)
            $display("PASS windowed_flow_bin_counter");
        else
            $display("FAIL windowed_flow_bin_counter");
        $finish;
    end

endmodule

[files.f]
sv/wfbc_pkg.sv
sv/wfbc_ram.sv
sv/windowed_flow_bin_counter.sv
sv/wfbc_checker.sv
verif/tb_windowed_flow_bin_counter.sv
